[design/pressure_temperature_compensation_top_macros.svh]
// -----------------------------------------------------------------------------
// Assertion macros for the pressure / temperature compensation block
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// -----------------------------------------------------------------------------
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH

// same-cycle implication
`define PTC_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ptc assertion failed");

// next-cycle implication
`define PTC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ptc assertion failed");

`endif

[design/ptc_pkg.sv]
// -----------------------------------------------------------------------------
// ptc_pkg
// Types, register indexes, constants and helpers of the compensation block.
// -----------------------------------------------------------------------------
package ptc_pkg;

   typedef logic [19:0]        raw_type;
   typedef logic signed [14:0] temp_type;
   typedef logic [31:0]        press_type;
   typedef logic [63:0]        word_type;
   typedef logic [1:0]         csr_idx_type;

   localparam csr_idx_type CSR_CAL_TEMP    = 2'd0;
   localparam csr_idx_type CSR_CAL_PRESS_A = 2'd1;
   localparam csr_idx_type CSR_CAL_PRESS_B = 2'd2;
   localparam csr_idx_type CSR_CAL_PRESS_C = 2'd3;

   localparam int TEMP_MIN_CENTI = -4000;
   localparam int TEMP_MAX_CENTI = 8500;

   localparam word_type V1_OFFSET    = 64'd128000;
   localparam word_type V1_BIAS      = 64'h0000_8000_0000_0000;
   localparam word_type PRESS_FULL   = 64'd1048576;
   localparam word_type PRESS_SCALE  = 64'd3125;

   function automatic word_type sx16(input logic [15:0] v);
      return {{48{v[15]}}, v};
   endfunction

endpackage

[design/ptc_if.sv]
// -----------------------------------------------------------------------------
// ptc_req_if / ptc_rsp_if
// Valid/ready channels carrying raw readings in and compensated words out.
// -----------------------------------------------------------------------------
interface ptc_req_if;
   import ptc_pkg::*;
   logic    valid;
   logic    ready;
   raw_type raw_temp;
   raw_type raw_press;
   modport source (output valid, output raw_temp, output raw_press, input ready);
   modport sink   (input valid, input raw_temp, input raw_press, output ready);
endinterface

interface ptc_rsp_if;
   import ptc_pkg::*;
   logic      valid;
   logic      ready;
   temp_type  temp_centi;
   press_type press_q24_8;
   logic      press_invalid;
   modport source (output valid, output temp_centi, output press_q24_8,
                   output press_invalid, input ready);
   modport sink   (input valid, input temp_centi, input press_q24_8,
                   input press_invalid, output ready);
endinterface

[design/pressure_temperature_compensation_top.sv]
// -----------------------------------------------------------------------------
// pressure_temperature_compensation_top
// Fixed-point barometric temperature and pressure compensation pipeline.
// -----------------------------------------------------------------------------
// Takes one raw temperature/pressure word per clock while the output is not
// stalled and returns one word per accepted word, in order, from the rsp
// register. The pressure path runs through the signed divider and the 64-bit
// multipliers around it; the whole pipeline freezes while a result waits at
// the output, so req ready follows rsp ready whenever the output register is
// full. Trim words must be written while the pipeline is empty.
// -----------------------------------------------------------------------------
module pressure_temperature_compensation_top (
   input  logic                 clock,
   input  logic                 reset,
   ptc_req_if.sink              req_chan,
   ptc_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  ptc_pkg::csr_idx_type csr_index,
   input  ptc_pkg::word_type    csr_wdata
);
   import ptc_pkg::*;

   localparam int LAST = 84;

   logic [47:0] cal_temp_ff;
   word_type    cal_press_a_ff, cal_press_b_ff;
   logic [15:0] cal_press_c_ff;

   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   word_type           p1, p2, p3, p4, p5, p6, p7, p8, p9;

   logic [LAST:0] vld_ff;
   logic          adv;

   raw_type            rt_ff;
   raw_type            rp_ff [0:10];
   logic signed [18:0] x1_in, x1_ff;
   logic signed [16:0] d_in, d_ff;
   logic signed [34:0] ax_in, ax_ff, dd_in, dd_ff;
   logic signed [23:0] a_in, a_ff;
   logic signed [22:0] dsh;
   logic signed [39:0] e_in, e_ff;
   logic signed [35:0] tf_in, tf_ff;
   logic signed [39:0] tcx, tcs;
   temp_type           tc_in;
   temp_type           tc_ff [5:83];
   word_type           v1_in, v1_ff;
   word_type           sq, v1p5, v1p2, sq6, sq3;
   word_type           m15_ff [8:9];
   word_type           m12_ff [8:9];
   word_type           v2_in, v2_ff, u_in, u_ff;
   word_type           pn, wv, nn, den_prod, num_prod;
   word_type           den_in, den_ff, num_ff;
   logic               zr_ff [13:83];
   word_type           quo, ps, p9ps, p8q, w1p;
   word_type           ps_ff  [80:81];
   word_type           q_ff   [80:83];
   word_type           p8q_ff [82:83];
   word_type           w1, w2, sum, pf;
   temp_type           temp_ff;
   press_type          press_in, press_ff;
   logic               inv_ff;

   // trim words
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_temp_ff    <= '0;
         cal_press_a_ff <= '0;
         cal_press_b_ff <= '0;
         cal_press_c_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAL_TEMP:    cal_temp_ff    <= csr_wdata[47:0];
            CSR_CAL_PRESS_A: cal_press_a_ff <= csr_wdata;
            CSR_CAL_PRESS_B: cal_press_b_ff <= csr_wdata;
            CSR_CAL_PRESS_C: cal_press_c_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      t1 = cal_temp_ff[15:0];
      t2 = $signed(cal_temp_ff[31:16]);
      t3 = $signed(cal_temp_ff[47:32]);
      p1 = {48'd0, cal_press_a_ff[15:0]};
      p2 = sx16(cal_press_a_ff[31:16]);
      p3 = sx16(cal_press_a_ff[47:32]);
      p4 = sx16(cal_press_a_ff[63:48]);
      p5 = sx16(cal_press_b_ff[15:0]);
      p6 = sx16(cal_press_b_ff[31:16]);
      p7 = sx16(cal_press_b_ff[47:32]);
      p8 = sx16(cal_press_b_ff[63:48]);
      p9 = sx16(cal_press_c_ff);
   end

   assign adv            = !vld_ff[LAST] || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_chan.valid};
      end
   end

   // temperature path
   always_comb begin
      x1_in = $signed({2'b00, rt_ff[19:3]}) - $signed({2'b00, t1, 1'b0});
      d_in  = $signed({1'b0, rt_ff[19:4]}) - $signed({1'b0, t1});
      ax_in = x1_ff * t2;
      dd_in = d_ff * d_ff;
      a_in  = 24'(ax_ff >>> 11);
      dsh   = 23'(dd_ff >>> 12);
      e_in  = dsh * t3;
      tf_in = 36'(a_ff) + 36'(e_ff >>> 14);
      tcx   = (40'(tf_ff) <<< 2) + 40'(tf_ff) + 40'sd128;
      tcs   = tcx >>> 8;
      if (tcs < TEMP_MIN_CENTI) begin
         tc_in = 15'(TEMP_MIN_CENTI);
      end else if (tcs > TEMP_MAX_CENTI) begin
         tc_in = 15'(TEMP_MAX_CENTI);
      end else begin
         tc_in = 15'(tcs);
      end
      v1_in = 64'(tf_ff) - V1_OFFSET;
   end

   // pressure path
   ptc_mul64 u_mul_sq (.clock, .en(adv), .a(v1_ff), .b(v1_ff), .p(sq));
   ptc_mul64 u_mul_p5 (.clock, .en(adv), .a(v1_ff), .b(p5),    .p(v1p5));
   ptc_mul64 u_mul_p2 (.clock, .en(adv), .a(v1_ff), .b(p2),    .p(v1p2));
   ptc_mul64 u_mul_p6 (.clock, .en(adv), .a(sq),    .b(p6),    .p(sq6));
   ptc_mul64 u_mul_p3 (.clock, .en(adv), .a(sq),    .b(p3),    .p(sq3));

   always_comb begin
      v2_in  = sq6 + (m15_ff[9] << 17) + (p4 << 35);
      u_in   = 64'($signed(sq3) >>> 8) + (m12_ff[9] << 12);
      pn     = PRESS_FULL - 64'(rp_ff[10]);
      wv     = V1_BIAS + u_ff;
      nn     = (pn << 31) - v2_ff;
      den_in = 64'($signed(den_prod) >>> 33);
   end

   ptc_mul64 u_mul_p1 (.clock, .en(adv), .a(wv), .b(p1),          .p(den_prod));
   ptc_mul64 u_mul_sc (.clock, .en(adv), .a(nn), .b(PRESS_SCALE), .p(num_prod));

   ptc_div64 u_div (.clock, .en(adv), .num(num_ff), .den(den_ff), .quo(quo));

   assign ps = 64'($signed(quo) >>> 13);

   ptc_mul64 u_mul_p9 (.clock, .en(adv), .a(p9),   .b(ps),        .p(p9ps));
   ptc_mul64 u_mul_p8 (.clock, .en(adv), .a(p8),   .b(quo),       .p(p8q));
   ptc_mul64 u_mul_w1 (.clock, .en(adv), .a(p9ps), .b(ps_ff[81]), .p(w1p));

   always_comb begin
      w1       = 64'($signed(w1p) >>> 25);
      w2       = 64'($signed(p8q_ff[83]) >>> 19);
      sum      = q_ff[83] + w1 + w2;
      pf       = 64'($signed(sum) >>> 8) + (p7 << 4);
      press_in = zr_ff[83] ? 32'd0 : pf[31:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rt_ff    <= req_chan.raw_temp;
         rp_ff[0] <= req_chan.raw_press;
         for (int k = 1; k <= 10; k++) begin
            rp_ff[k] <= rp_ff[k-1];
         end
         x1_ff <= x1_in;
         d_ff  <= d_in;
         ax_ff <= ax_in;
         dd_ff <= dd_in;
         a_ff  <= a_in;
         e_ff  <= e_in;
         tf_ff <= tf_in;
         v1_ff <= v1_in;
         tc_ff[5] <= tc_in;
         for (int k = 6; k <= 83; k++) begin
            tc_ff[k] <= tc_ff[k-1];
         end
         m15_ff[8] <= v1p5;
         m15_ff[9] <= m15_ff[8];
         m12_ff[8] <= v1p2;
         m12_ff[9] <= m12_ff[8];
         v2_ff  <= v2_in;
         u_ff   <= u_in;
         den_ff <= den_in;
         num_ff <= num_prod;
         zr_ff[13] <= (den_in == 64'd0);
         for (int k = 14; k <= 83; k++) begin
            zr_ff[k] <= zr_ff[k-1];
         end
         ps_ff[80] <= ps;
         ps_ff[81] <= ps_ff[80];
         q_ff[80]  <= quo;
         for (int k = 81; k <= 83; k++) begin
            q_ff[k] <= q_ff[k-1];
         end
         p8q_ff[82] <= p8q;
         p8q_ff[83] <= p8q_ff[82];
         temp_ff  <= tc_ff[83];
         press_ff <= press_in;
         inv_ff   <= zr_ff[83];
      end
   end

   assign rsp_chan.valid         = vld_ff[LAST];
   assign rsp_chan.temp_centi    = temp_ff;
   assign rsp_chan.press_q24_8   = press_ff;
   assign rsp_chan.press_invalid = inv_ff;
endmodule

[design/ptc_mul64.sv]
// -----------------------------------------------------------------------------
// ptc_mul64
// Two-stage low-64-bit product from three 32x32 partial products.
// -----------------------------------------------------------------------------
module ptc_mul64 (
   input  logic              clock,
   input  logic              en,
   input  ptc_pkg::word_type a,
   input  ptc_pkg::word_type b,
   output ptc_pkg::word_type p
);
   import ptc_pkg::*;

   logic [63:0] lo_in, lo_ff;
   logic [31:0] cross_in, cross_ff;
   word_type    p_in, p_ff;

   always_comb begin
      lo_in    = 64'(a[31:0]) * 64'(b[31:0]);
      cross_in = 32'(a[63:32] * b[31:0]) + 32'(a[31:0] * b[63:32]);
      p_in     = lo_ff + {cross_ff, 32'd0};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff    <= lo_in;
         cross_ff <= cross_in;
         p_ff     <= p_in;
      end
   end

   assign p = p_ff;
endmodule

[design/ptc_div64.sv]
// -----------------------------------------------------------------------------
// ptc_div64
// Pipelined signed 64-bit divide, one quotient bit per stage, truncating.
// Divisor of zero yields an unspecified quotient.
// -----------------------------------------------------------------------------
module ptc_div64 (
   input  logic              clock,
   input  logic              en,
   input  ptc_pkg::word_type num,
   input  ptc_pkg::word_type den,
   output ptc_pkg::word_type quo
);
   import ptc_pkg::*;

   word_type    rem_ff [0:64];
   word_type    dq_ff  [0:64];
   word_type    dv_ff  [0:64];
   logic        neg_ff [0:64];
   word_type    rem_in [1:64];
   word_type    dq_in  [1:64];
   logic [64:0] trial  [1:64];
   word_type    quo_in, quo_ff;

   always_comb begin
      for (int k = 1; k <= 64; k++) begin
         trial[k]  = {rem_ff[k-1], dq_ff[k-1][63]} - {1'b0, dv_ff[k-1]};
         rem_in[k] = trial[k][64] ? {rem_ff[k-1][62:0], dq_ff[k-1][63]} : trial[k][63:0];
         dq_in[k]  = {dq_ff[k-1][62:0], ~trial[k][64]};
      end
      quo_in = neg_ff[64] ? 64'd0 - dq_ff[64] : dq_ff[64];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         dq_ff[0]  <= num[63] ? 64'd0 - num : num;
         dv_ff[0]  <= den[63] ? 64'd0 - den : den;
         neg_ff[0] <= num[63] ^ den[63];
         for (int k = 1; k <= 64; k++) begin
            rem_ff[k] <= rem_in[k];
            dq_ff[k]  <= dq_in[k];
            dv_ff[k]  <= dv_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
         end
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;
endmodule

[design/ptc_checker.sv]
// -----------------------------------------------------------------------------
// ptc_assert
// Port-level checks of the compensation block, bound to the top level.
// -----------------------------------------------------------------------------
`include "pressure_temperature_compensation_top_macros.svh"

module ptc_assert (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ptc_pkg::temp_type    temp_centi,
   input ptc_pkg::press_type   press_q24_8,
   input logic                 press_invalid
);
   import ptc_pkg::*;

   `PTC_ASSERT_SAME(a_invalid_zero, rsp_valid && press_invalid, press_q24_8 == 32'd0)
   `PTC_ASSERT_SAME(a_temp_range, rsp_valid, (temp_centi >= TEMP_MIN_CENTI) && (temp_centi <= TEMP_MAX_CENTI))
   `PTC_ASSERT_SAME(a_free_ready, !rsp_valid, req_ready)
   `PTC_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(press_q24_8) && $stable(temp_centi))
endmodule

bind pressure_temperature_compensation_top ptc_assert u_ptc_assert (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .temp_centi    (rsp_chan.temp_centi),
   .press_q24_8   (rsp_chan.press_q24_8),
   .press_invalid (rsp_chan.press_invalid)
);
